FILE: hdl/sh24_pkg.sv
// Shared types, constants and helpers for the SipHash-2-4 keyed hash engine.
package sh24_pkg;

   // Width of one SipHash lane and of one message word.
   localparam int unsigned LANE_W = 64;
   localparam int unsigned FOLD_W = LANE_W / 2;
   localparam int unsigned LEN_W  = 8;
   localparam int unsigned TAIL_W = 3;
   localparam int unsigned BYTES_PER_WORD = LANE_W / 8;

   typedef logic [LANE_W-1:0] lane_word_type;

   // The four lanes v0..v3, v0 at index 0.
   typedef lane_word_type [3:0] lane_set_type;

   // Initialisation constants, xored with the key at the start of a message.
   localparam lane_word_type INIT_V0 = 64'h736f6d65_70736575;
   localparam lane_word_type INIT_V1 = 64'h646f7261_6e646f6d;
   localparam lane_word_type INIT_V2 = 64'h6c796765_6e657261;
   localparam lane_word_type INIT_V3 = 64'h74656462_79746573;

   // Finalisation constant xored into v2, and the position of the length byte.
   localparam lane_word_type FINAL_XOR = 64'h0000_0000_0000_00ff;
   localparam int unsigned   LEN_SHIFT = 56;

   // Configuration register indexes.
   localparam logic [0:0] CSR_KEY_LOW  = 1'b0;
   localparam logic [0:0] CSR_KEY_HIGH = 1'b1;

   // Index of the last round for an absorbed word and of the last finalisation round.
   localparam logic [1:0] LAST_ABSORB_ROUND = 2'd1;
   localparam logic [1:0] LAST_FINAL_ROUND  = 2'd3;

   // Lower-case every ASCII capital letter in a word; other bytes pass unchanged.
   function automatic lane_word_type fold_ascii(input lane_word_type w);
      lane_word_type r;
      logic [7:0]    c;
      r = '0;
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         c = w[8*i +: 8];
         if (c inside {[8'h41:8'h5a]}) begin
            c = c + 8'h20;
         end
         r[8*i +: 8] = c;
      end
      return r;
   endfunction

   // Keep the first n bytes of a word and clear the rest.
   function automatic lane_word_type keep_bytes(input lane_word_type w,
                                                input logic [TAIL_W-1:0] n);
      lane_word_type r;
      r = '0;
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         if (i < int'(n)) begin
            r[8*i +: 8] = w[8*i +: 8];
         end
      end
      return r;
   endfunction

endpackage

FILE: hdl/sh24_if.sv
// Valid/ready stream interfaces for the message words and the hash results.
interface sh24_req_if
   import sh24_pkg::*;
();
   logic                valid;
   logic                ready;
   lane_word_type       message_word;
   logic [TAIL_W-1:0]   tail_bytes;
   logic                last_word;
   logic                fold_case;

   modport source (output valid, message_word, tail_bytes, last_word, fold_case,
                   input ready);
   modport sink   (input valid, message_word, tail_bytes, last_word, fold_case,
                   output ready);
endinterface

interface sh24_rsp_if
   import sh24_pkg::*;
();
   logic                valid;
   logic                ready;
   lane_word_type       hash_full;
   logic [FOLD_W-1:0]   hash_folded;

   modport source (output valid, hash_full, hash_folded, input ready);
   modport sink   (input valid, hash_full, hash_folded, output ready);
endinterface

FILE: hdl/sh24_round.sv
// One SipRound over the four lanes, the shared mixing unit of the engine.
module sh24_round
   import sh24_pkg::*;
(
   input  lane_set_type lanes_i,
   output lane_set_type lanes_o
);

   lane_word_type a0, a1, a2, a3;
   lane_word_type b0, b1, b2, b3;
   lane_word_type c0, c1, c2, c3;

   // First half: the two add-rotate-xor pairs.
   always_comb begin
      a0 = lanes_i[0] + lanes_i[1];
      a1 = {lanes_i[1][LANE_W-14:0], lanes_i[1][LANE_W-1 -: 13]} ^ a0;
      b0 = {a0[LANE_W-33:0], a0[LANE_W-1 -: 32]};
      a2 = lanes_i[2] + lanes_i[3];
      a3 = {lanes_i[3][LANE_W-17:0], lanes_i[3][LANE_W-1 -: 16]} ^ a2;
   end

   // Second half: cross the pairs over.
   always_comb begin
      c0 = b0 + a3;
      b3 = {a3[LANE_W-22:0], a3[LANE_W-1 -: 21]} ^ c0;
      b2 = a2 + a1;
      b1 = {a1[LANE_W-18:0], a1[LANE_W-1 -: 17]} ^ b2;
      c2 = {b2[LANE_W-33:0], b2[LANE_W-1 -: 32]};
      c1 = b1;
      c3 = b3;
   end

   assign lanes_o = {c3, c2, c1, c0};

endmodule

FILE: hdl/siphash24_keyed_hash_top.sv
// SipHash-2-4 keyed hash engine: sequencer, lanes, key registers and output register.
// A non-last word is accepted, then takes two absorb rounds before the sequencer returns to idle.
// A last word takes 2 absorb + 4 final rounds and then a hand-over step: its hash beat becomes valid
// in the same cycle as the engine returns to idle, so the next word may be accepted with that beat.
// Rounds run one per cycle in one shared SipRound unit; a held hash beat stalls the hand-over.
// Synchronous active-high reset clears the keys, lanes, length, sequencer and result valid.
module siphash24_keyed_hash_top
   import sh24_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sh24_req_if.sink          req_if,
   sh24_rsp_if.source        rsp_if,
   input  logic              csr_wr_en,
   input  logic [0:0]        csr_index,
   input  lane_word_type     csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ABSORB = 4'b0010,
      S_FINAL  = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   lane_word_type      key_low_ff, key_low_in;
   lane_word_type      key_high_ff, key_high_in;
   lane_set_type       lanes_ff, lanes_in;
   lane_word_type      msg_ff, msg_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [1:0]         round_ff, round_in;
   logic               in_message_ff, in_message_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lane_word_type      hash_ff, hash_in;

   lane_set_type       round_out;
   lane_set_type       start_lanes;
   lane_word_type      word_folded;
   lane_word_type      absorb_word;
   logic [LEN_W-1:0]   length_base;
   logic [LEN_W-1:0]   length_next;
   logic               accept;
   logic               rsp_free;

   // Shared mixing unit, always fed from the lane registers.
   sh24_round u_round (
      .lanes_i (lanes_ff),
      .lanes_o (round_out)
   );

   assign accept   = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // Key registers.
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_in  = csr_wr_data;
            CSR_KEY_HIGH: key_high_in = csr_wr_data;
            default:      key_low_in  = key_low_ff;
         endcase
      end
   end

   // Word preparation: fresh lanes at message start, case folding, tail and length.
   always_comb begin
      start_lanes[0] = INIT_V0 ^ key_low_ff;
      start_lanes[1] = INIT_V1 ^ key_high_ff;
      start_lanes[2] = INIT_V2 ^ key_low_ff;
      start_lanes[3] = INIT_V3 ^ key_high_ff;
      if (in_message_ff) begin
         start_lanes = lanes_ff;
      end
      length_base = in_message_ff ? length_ff : '0;
      word_folded = req_if.fold_case ? fold_ascii(req_if.message_word)
                                     : req_if.message_word;
      if (req_if.last_word) begin
         length_next = length_base + LEN_W'(req_if.tail_bytes);
         absorb_word = keep_bytes(word_folded, req_if.tail_bytes)
                       | (lane_word_type'(length_next) << LEN_SHIFT);
      end else begin
         length_next = length_base + LEN_W'(BYTES_PER_WORD);
         absorb_word = word_folded;
      end
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in      = state_ff;
      lanes_in      = lanes_ff;
      msg_in        = msg_ff;
      length_in     = length_ff;
      round_in      = round_ff;
      in_message_in = in_message_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      hash_in       = hash_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lanes_in      = start_lanes;
               lanes_in[3]   = start_lanes[3] ^ absorb_word;
               msg_in        = absorb_word;
               length_in     = length_next;
               last_in       = req_if.last_word;
               in_message_in = in_message_ff || !req_if.last_word;
               round_in      = '0;
               state_in      = S_ABSORB;
            end
         end
         S_ABSORB: begin
            lanes_in = round_out;
            round_in = round_ff + 2'd1;
            if (round_ff == LAST_ABSORB_ROUND) begin
               lanes_in[0] = round_out[0] ^ msg_ff;
               round_in    = '0;
               if (last_ff) begin
                  lanes_in[2] = round_out[2] ^ FINAL_XOR;
                  state_in    = S_FINAL;
               end else begin
                  state_in    = S_IDLE;
               end
            end
         end
         S_FINAL: begin
            lanes_in = round_out;
            round_in = round_ff + 2'd1;
            if (round_ff == LAST_FINAL_ROUND) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Wait for the output register to be free, then hand over the hash.
            if (rsp_free) begin
               hash_in       = lanes_ff[0] ^ lanes_ff[1] ^ lanes_ff[2] ^ lanes_ff[3];
               rsp_valid_in  = 1'b1;
               in_message_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         lanes_ff      <= '0;
         length_ff     <= '0;
         round_ff      <= '0;
         in_message_ff <= 1'b0;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_low_ff    <= key_low_in;
         key_high_ff   <= key_high_in;
         lanes_ff      <= lanes_in;
         length_ff     <= length_in;
         round_ff      <= round_in;
         in_message_ff <= in_message_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff  <= msg_in;
      hash_ff <= hash_in;
   end

   // Ports.
   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.hash_full   = hash_ff;
   assign rsp_if.hash_folded = hash_ff[FOLD_W-1:0] ^ hash_ff[LANE_W-1:FOLD_W];

   // A new result beat only ever comes out of the done state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   // A message ends only when its hash is handed over.
   assert property (@(posedge clock) disable iff (reset)
      $fell(in_message_ff) |-> $past(state_ff == S_DONE))
      else $error("message state cleared before the hash was produced");

   // An accepted word always starts its two absorb rounds.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_ABSORB) && (round_ff == 2'd0))
      else $error("accepted word did not enter the absorb rounds");

   // Finalisation is only reached for a last word.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL) |-> last_ff)
      else $error("finalisation entered for a non-last word");

endmodule

FILE: tb/sh24_tb_pkg.sv
// SipHash-2-4 hash predictor and result scoreboard for the keyed hash testbench.
`timescale 1ns / 100ps
package sh24_tb_pkg;
   import sh24_pkg::*;

   typedef struct packed {
      lane_word_type     full;
      logic [FOLD_W-1:0] folded;
   } hash_beat_type;

   class siphash_predictor;
      lane_word_type    key_lo = '0;
      lane_word_type    key_hi = '0;
      lane_word_type    lanes [4];
      logic [LEN_W-1:0] byte_len = '0;
      bit               open_msg = 1'b0;
      hash_beat_type    hashes_due [$];
      int unsigned      faults = 0;

      // Keep a copy of the key; the block is idle whenever it changes.
      function void set_key(logic [0:0] idx, lane_word_type data);
         if (idx == CSR_KEY_LOW) begin
            key_lo = data;
         end else begin
            key_hi = data;
         end
      endfunction

      function lane_word_type rotl(lane_word_type x, int unsigned b);
         return (x << b) | (x >> (LANE_W - b));
      endfunction

      // One SipRound over the four lanes.
      function void mix_round();
         lane_word_type v0, v1, v2, v3;
         v0 = lanes[0];
         v1 = lanes[1];
         v2 = lanes[2];
         v3 = lanes[3];
         v0 = v0 + v1; v1 = rotl(v1, 13); v1 = v1 ^ v0; v0 = rotl(v0, 32);
         v2 = v2 + v3; v3 = rotl(v3, 16); v3 = v3 ^ v2;
         v0 = v0 + v3; v3 = rotl(v3, 21); v3 = v3 ^ v0;
         v2 = v2 + v1; v1 = rotl(v1, 17); v1 = v1 ^ v2; v2 = rotl(v2, 32);
         lanes[0] = v0;
         lanes[1] = v1;
         lanes[2] = v2;
         lanes[3] = v3;
      endfunction

      function void absorb(lane_word_type m);
         lanes[3] = lanes[3] ^ m;
         mix_round();
         mix_round();
         lanes[0] = lanes[0] ^ m;
      endfunction

      // Capital ASCII letters become lower case; every other byte is left alone.
      function lane_word_type lower_ascii(lane_word_type w);
         logic [7:0] c;
         for (int i = 0; i < BYTES_PER_WORD; i++) begin
            c = w[8*i +: 8];
            if (c >= 8'h41 && c <= 8'h5a) begin
               c = c + 8'h20;
            end
            w[8*i +: 8] = c;
         end
         return w;
      endfunction

      // Advance the hash state by one accepted word; a last word yields a hash.
      function void note_word(lane_word_type w, logic [TAIL_W-1:0] tail, logic last,
                              logic fold);
         lane_word_type m;
         hash_beat_type beat;
         if (!open_msg) begin
            lanes[0] = INIT_V0 ^ key_lo;
            lanes[1] = INIT_V1 ^ key_hi;
            lanes[2] = INIT_V2 ^ key_lo;
            lanes[3] = INIT_V3 ^ key_hi;
            byte_len = '0;
         end
         m = fold ? lower_ascii(w) : w;
         if (!last) begin
            absorb(m);
            byte_len = byte_len + LEN_W'(BYTES_PER_WORD);
            open_msg = 1'b1;
            return;
         end
         // Bytes beyond the tail count are dropped and the wrapped length goes on top.
         for (int i = 0; i < BYTES_PER_WORD; i++) begin
            if (i >= int'(tail)) begin
               m[8*i +: 8] = 8'h00;
            end
         end
         byte_len = byte_len + LEN_W'(tail);
         absorb(m | (lane_word_type'(byte_len) << LEN_SHIFT));
         lanes[2] = lanes[2] ^ FINAL_XOR;
         for (int r = 0; r < 4; r++) begin
            mix_round();
         end
         beat.full   = lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3];
         beat.folded = beat.full[FOLD_W-1:0] ^ beat.full[LANE_W-1:FOLD_W];
         hashes_due.push_back(beat);
         open_msg = 1'b0;
      endfunction

      function void flag_fault(string what);
         faults++;
         if (faults <= 10) begin
            $display("%s", what);
         end
      endfunction

      // Compare one hash beat with the oldest outstanding prediction.
      function void check_hash(lane_word_type full, logic [FOLD_W-1:0] folded);
         hash_beat_type want;
         if (hashes_due.size() == 0) begin
            flag_fault($sformatf("hash beat with no message outstanding: full %h folded %h",
                                 full, folded));
            return;
         end
         want = hashes_due.pop_front();
         if (full !== want.full) begin
            flag_fault($sformatf("hash_full mismatch: expected %h actual %h",
                                 want.full, full));
         end
         if (folded !== want.folded) begin
            flag_fault($sformatf("hash_folded mismatch: expected %h actual %h",
                                 want.folded, folded));
         end
      endfunction

      function int unsigned waiting();
         return hashes_due.size();
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench for the SipHash-2-4 keyed hash engine.
`timescale 1ns / 100ps
module tb_top;
   import sh24_pkg::*;
   import sh24_tb_pkg::*;

   localparam int unsigned PHASE_WORDS   = 250;
   localparam int unsigned PHASE_COUNT   = 5;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned LONG_HOLD     = 400;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   localparam logic [7:0] EDGE_BYTES [8] = '{8'h40, 8'h41, 8'h5a, 8'h5b,
                                            8'h60, 8'h7b, 8'h80, 8'hff};

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_wr_en;
   logic [0:0]    csr_index;
   lane_word_type csr_wr_data;

   sh24_req_if req_ch ();
   sh24_rsp_if rsp_ch ();

   siphash24_keyed_hash_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   siphash_predictor hasher = new();

   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   int unsigned cycles = 0;
   bit          no_gaps = 1'b0;
   bit          long_hold_req = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watch both channels: note every accepted word, check every accepted hash.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            hasher.note_word(req_ch.message_word, req_ch.tail_bytes, req_ch.last_word,
                             req_ch.fold_case);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            hasher.check_hash(rsp_ch.hash_full, rsp_ch.hash_folded);
         end
      end
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("siphash24_keyed_hash_top verification failed");
         $finish;
      end
   end

   // The receiver stalls in spans of its own choosing, with one long hold-off on request.
   initial begin
      int unsigned mode;
      int unsigned span;
      forever begin
         if (long_hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            for (int k = 0; k < span; k++) begin
               case (mode)
                  0: begin
                     rsp_ch.ready <= 1'b1;
                  end
                  1: begin
                     rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                  end
                  2: begin
                     rsp_ch.ready <= 1'($urandom_range(0, 1));
                  end
                  default: begin
                     rsp_ch.ready <= (k >= span / 2);
                  end
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0, 1: begin
            return 8'($urandom_range(8'h41, 8'h5a));
         end
         2: begin
            return EDGE_BYTES[$urandom_range(0, 7)];
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic lane_word_type pick_word();
      lane_word_type w;
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         w[8*i +: 8] = pick_byte();
      end
      return w;
   endfunction

   // Offer one beat and hold it until taken; bursts are broken by random gaps.
   task automatic put_word(lane_word_type w, logic [TAIL_W-1:0] tail, logic last,
                           logic fold);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.message_word <= w;
      req_ch.tail_bytes   <= tail;
      req_ch.last_word    <= last;
      req_ch.fold_case    <= fold;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   // A message of whole words and a tail; the fold bit is now and then flipped on a word.
   task automatic send_message(int unsigned full_words, logic [TAIL_W-1:0] tail,
                               logic fold);
      for (int i = 0; i < full_words; i++) begin
         put_word(pick_word(), TAIL_W'($urandom), 1'b0,
                  ($urandom_range(0, 19) == 0) ? ~fold : fold);
      end
      put_word(pick_word(), tail, 1'b1, fold);
   endtask

   // Stop sending, wait for every hash, then let the engine finish any absorb.
   task automatic drain_all();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (hasher.waiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keys(lane_word_type lo, lane_word_type hi);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_KEY_LOW;
      csr_wr_data <= lo;
      @(posedge clock);
      hasher.set_key(CSR_KEY_LOW, lo);
      csr_index   <= CSR_KEY_HIGH;
      csr_wr_data <= hi;
      @(posedge clock);
      hasher.set_key(CSR_KEY_HIGH, hi);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int unsigned phase_start;
      int unsigned full_words;
      int unsigned roll;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_KEY_LOW;
      csr_wr_data         <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.message_word <= '0;
      req_ch.tail_bytes   <= '0;
      req_ch.last_word    <= 1'b0;
      req_ch.fold_case    <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_keys('0, '0);

      // Empty message with garbage in every ignored byte, then full seven-byte tails.
      put_word('1, 3'd0, 1'b1, 1'b0);
      put_word('0, 3'd7, 1'b1, 1'b0);
      put_word('1, 3'd7, 1'b1, 1'b1);
      // Bytes either side of the capital range, and high bytes that must not fold.
      put_word(64'h7b7a6160_5b5a4140, 3'd5, 1'b0, 1'b1);
      put_word(64'h3322_4e4d_ff80_dac1, 3'd6, 1'b1, 1'b1);
      put_word(64'h7b7a6160_5b5a4140, 3'd5, 1'b0, 1'b0);
      put_word(64'h3322_4e4d_ff80_dac1, 3'd6, 1'b1, 1'b0);
      for (int t = 1; t <= 5; t++) begin
         put_word(pick_word(), TAIL_W'(t), 1'b1, 1'b0);
      end
      drain_all();

      // All-ones key.
      write_keys('1, '1);
      put_word('1, 3'd7, 1'b1, 1'b0);
      put_word('1, 3'd2, 1'b0, 1'b0);
      put_word('1, 3'd0, 1'b1, 1'b0);
      drain_all();

      // A key written mid-message must only take effect on the next message.
      write_keys({$urandom, $urandom}, {$urandom, $urandom});
      put_word(pick_word(), 3'd1, 1'b0, 1'b1);
      put_word(pick_word(), 3'd3, 1'b0, 1'b1);
      drain_all();
      write_keys({$urandom, $urandom}, {$urandom, $urandom});
      put_word(pick_word(), 3'd4, 1'b1, 1'b1);
      put_word(pick_word(), 3'd4, 1'b1, 1'b1);
      drain_all();

      // Random messages under several keys; a few are long enough to wrap the length.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            1: begin
               write_keys('0, '1);
            end
            2: begin
               write_keys('1, '0);
            end
            default: begin
               write_keys({$urandom, $urandom}, {$urandom, $urandom});
            end
         endcase
         if (p == 1) begin
            long_hold_req = 1'b1;
         end
         no_gaps = (p == PHASE_COUNT - 1);
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               full_words = $urandom_range(32, 40);
            end else begin
               full_words = $urandom_range(0, 4);
            end
            send_message(full_words, TAIL_W'($urandom), 1'($urandom_range(0, 1)));
         end
         drain_all();
      end

      if (hasher.waiting() != 0) begin
         hasher.flag_fault($sformatf("%0d hashes never arrived", hasher.waiting()));
      end
      if (hasher.faults == 0) begin
         $display("siphash24_keyed_hash_top verification clean");
      end else begin
         $display("siphash24_keyed_hash_top verification failed");
      end
      $finish;
   end

endmodule
